// ===== hdl/ffsa_pkg.sv =====
`default_nettype none

package ffsa_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_ENTRIES      = 1024;
    localparam int DEF_SECTORS      = 4096;
    localparam int DEF_SECTOR_SHIFT = 12;

    // Fixed field widths of the request and response beats.
    localparam int INDEX_W  = 10;
    localparam int BYTES_W  = 32;
    localparam int START_W  = 12;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 3;

    // The free bitmap is stored and searched one word at a time.
    localparam int WORD_W = 64;
    localparam int OFF_W  = 6;

    // A run must start below this sector so that it fits the start field.
    localparam int START_LIMIT = 4096;
    localparam int MAX_RUN     = 255;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED   = 3'd0,
        ST_PLACED   = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_TOOLARGE = 3'd3,
        ST_RESTORED = 3'd4
    } status_t;

    // Which run the bitmap marking engine works on.
    typedef enum logic [1:0] {
        MSRC_OLD   = 2'd0,
        MSRC_REST  = 2'd1,
        MSRC_FOUND = 2'd2
    } mark_src_t;

    // What gets written into the entry table.
    typedef enum logic [1:0] {
        EWR_ZERO  = 2'd0,
        EWR_REST  = 2'd1,
        EWR_FOUND = 2'd2
    } ent_src_t;

    typedef struct packed {
        logic      clear_wr;
        logic      take;
        logic      ent_we;
        ent_src_t  ent_src;
        logic      res_load;
        status_t   res_status;
        logic      mark_load;
        mark_src_t mark_src;
        logic      mark_rd;
        logic      mark_wr;
        logic      scan_start;
        logic      scan_step;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic idx_bad;
        logic is_restore;
        logic too_large;
        logic reuse;
        logic old_empty;
        logic rest_empty;
        logic mark_last;
        logic scan_hit;
        logic scan_fit;
        logic scan_last;
        logic clear_last;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/ffsa_ifs.sv =====
`default_nettype none

interface ffsa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [ffsa_pkg::INDEX_W-1:0] entry_index;
    logic [ffsa_pkg::BYTES_W-1:0] needed_bytes;
    logic [ffsa_pkg::START_W-1:0] restore_start;
    logic [ffsa_pkg::COUNT_W-1:0] restore_count;

    modport source (
        output valid, operation, entry_index, needed_bytes, restore_start, restore_count,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, needed_bytes, restore_start, restore_count,
        output ready
    );
endinterface

interface ffsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffsa_pkg::STATUS_W-1:0] status;
    logic [ffsa_pkg::START_W-1:0]  start_sector;
    logic [ffsa_pkg::COUNT_W-1:0]  sector_count;

    modport source (
        output valid, status, start_sector, sector_count,
        input  ready
    );
    modport sink (
        input  valid, status, start_sector, sector_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/first_fit_sector_allocator.sv =====
// A restore of no sectors, a rejected or too-large request and a reuse finish right after the entry lookup.
// Marking or freeing a run reads and writes each 64-sector bitmap word it touches (at most 5).
// The first-fit search reads the bitmap one word at a time (up to 64 words at the default
// size), and a placing allocate then marks its new run.
// One request is in work at a time; the next beat is taken while a result waits to drain.
// After reset a clearing pass over the entry table and the free bitmap runs first.
`default_nettype none

module first_fit_sector_allocator #(
    parameter int ENTRIES      = ffsa_pkg::DEF_ENTRIES,
    parameter int SECTORS      = ffsa_pkg::DEF_SECTORS,
    parameter int SECTOR_SHIFT = ffsa_pkg::DEF_SECTOR_SHIFT
) (
    input wire logic  clk,
    input wire logic  rst_n,
    ffsa_req_if.sink  req,
    ffsa_rsp_if.source rsp
);

    // The controller sequences each request through lookup, optional freeing
    // of the old run, the word-by-word first-fit search and the marking of the
    // new run. The datapath owns the entry table, the free bitmap and all the
    // arithmetic; the two talk only through the command and status structs.
    ffsa_pkg::cmd_t cmd;
    ffsa_pkg::sts_t sts;
    logic           out_valid;
    logic           in_ready;

    ffsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The bitmap is held as 64-bit words with a set bit meaning free. The
    // search keeps the length of the free run that reaches the end of the
    // previous word, so runs that cross word boundaries are found too.
    ffsa_dp #(
        .ENTRIES      (ENTRIES),
        .SECTORS      (SECTORS),
        .SECTOR_SHIFT (SECTOR_SHIFT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (req.operation),
        .entry_index   (req.entry_index),
        .needed_bytes  (req.needed_bytes),
        .restore_start (req.restore_start),
        .restore_count (req.restore_count),
        .status        (rsp.status),
        .start_sector  (rsp.start_sector),
        .sector_count  (rsp.sector_count)
    );

    // The request side is ready only between operations; the response beat
    // sits in its own register, so a slow sink delays only the final step.
    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

    // A failed request never reports a run.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ffsa_pkg::ST_NOSPACE ||
                      rsp.status == ffsa_pkg::ST_TOOLARGE)
        |-> rsp.start_sector == '0 && rsp.sector_count == '0)
        else $error("failed request reports a nonzero run");

    // A newly placed run always holds at least one sector.
    a_placed_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ffsa_pkg::ST_PLACED |-> rsp.sector_count != '0)
        else $error("placed run has no sectors");

    // Requests are processed one at a time: an accepted beat closes the input.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("input accepted while a request is in work");

endmodule

`default_nettype wire

// ===== hdl/ffsa_ram.sv =====
`default_nettype none

module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/ffsa_ctrl.sv =====
`default_nettype none

module ffsa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire ffsa_pkg::sts_t sts,
    output ffsa_pkg::cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_CLEAR      = 8'b0000_0001,
        S_IDLE       = 8'b0000_0010,
        S_LOOKUP     = 8'b0000_0100,
        S_MARK_RD    = 8'b0000_1000,
        S_MARK_WR    = 8'b0001_0000,
        S_SCAN_START = 8'b0010_0000,
        S_SCAN       = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   freeing_reg;
    logic   freeing_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        freeing_next = freeing_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.res_load = 1'b1;
                if (sts.idx_bad)
                begin
                    cmd.res_status = ffsa_pkg::ST_NOSPACE;
                    state_next     = S_FINISH;
                end
                else if (sts.is_restore)
                begin
                    cmd.ent_we     = 1'b1;
                    cmd.ent_src    = ffsa_pkg::EWR_REST;
                    cmd.res_status = ffsa_pkg::ST_RESTORED;
                    if (sts.rest_empty)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.mark_load = 1'b1;
                        cmd.mark_src  = ffsa_pkg::MSRC_REST;
                        freeing_next  = 1'b0;
                        state_next    = S_MARK_RD;
                    end
                end
                else if (sts.too_large)
                begin
                    cmd.res_status = ffsa_pkg::ST_TOOLARGE;
                    state_next     = S_FINISH;
                end
                else if (sts.reuse)
                begin
                    cmd.res_status = ffsa_pkg::ST_REUSED;
                    state_next     = S_FINISH;
                end
                else
                begin
                    // The record is cleared now; a successful search rewrites it.
                    cmd.ent_we     = 1'b1;
                    cmd.ent_src    = ffsa_pkg::EWR_ZERO;
                    cmd.res_status = ffsa_pkg::ST_NOSPACE;
                    if (sts.old_empty)
                    begin
                        state_next = S_SCAN_START;
                    end
                    else
                    begin
                        cmd.mark_load = 1'b1;
                        cmd.mark_src  = ffsa_pkg::MSRC_OLD;
                        freeing_next  = 1'b1;
                        state_next    = S_MARK_RD;
                    end
                end
            end
            S_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                if (!sts.mark_last)
                begin
                    state_next = S_MARK_RD;
                end
                else if (freeing_reg)
                begin
                    state_next = S_SCAN_START;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    if (sts.scan_fit)
                    begin
                        cmd.ent_we     = 1'b1;
                        cmd.ent_src    = ffsa_pkg::EWR_FOUND;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ffsa_pkg::ST_PLACED;
                        cmd.mark_load  = 1'b1;
                        cmd.mark_src   = ffsa_pkg::MSRC_FOUND;
                        freeing_next   = 1'b0;
                        state_next     = S_MARK_RD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            freeing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            freeing_reg   <= freeing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/ffsa_dp.sv =====
`default_nettype none

module ffsa_dp #(
    parameter int ENTRIES      = ffsa_pkg::DEF_ENTRIES,
    parameter int SECTORS      = ffsa_pkg::DEF_SECTORS,
    parameter int SECTOR_SHIFT = ffsa_pkg::DEF_SECTOR_SHIFT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ffsa_pkg::cmd_t                cmd,
    output ffsa_pkg::sts_t                     sts,
    input  wire logic                          operation,
    input  wire logic [ffsa_pkg::INDEX_W-1:0]  entry_index,
    input  wire logic [ffsa_pkg::BYTES_W-1:0]  needed_bytes,
    input  wire logic [ffsa_pkg::START_W-1:0]  restore_start,
    input  wire logic [ffsa_pkg::COUNT_W-1:0]  restore_count,
    output logic      [ffsa_pkg::STATUS_W-1:0] status,
    output logic      [ffsa_pkg::START_W-1:0]  start_sector,
    output logic      [ffsa_pkg::COUNT_W-1:0]  sector_count
);

    localparam int WORD_W    = ffsa_pkg::WORD_W;
    localparam int OFF_W     = ffsa_pkg::OFF_W;
    localparam int START_W   = ffsa_pkg::START_W;
    localparam int COUNT_W   = ffsa_pkg::COUNT_W;
    localparam int INDEX_W   = ffsa_pkg::INDEX_W;
    localparam int NWORDS    = (SECTORS + WORD_W - 1) / WORD_W;
    localparam int TAIL_PAD  = NWORDS * WORD_W - SECTORS;
    localparam int EA_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WA_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SEC_W     = $clog2(SECTORS);
    localparam int CALC_W    = ((SEC_W > START_W + 1) ? SEC_W : START_W + 1) + 1;
    localparam int CLEAR_LEN = (ENTRIES > NWORDS) ? ENTRIES : NWORDS;
    localparam int CLR_W     = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;
    localparam int ENT_W     = START_W + COUNT_W;
    localparam int RUN_W     = COUNT_W + 1;
    localparam int LZ_W      = OFF_W + 1;

    // Request held for the whole operation.
    logic                 op_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [COUNT_W-1:0]   needed_reg;
    logic                 too_large_reg;
    logic [START_W-1:0]   rstart_reg;
    logic [COUNT_W-1:0]   rcount_reg;
    logic [31:0]          shifted;

    // Clearing pass counter.
    logic [CLR_W-1:0]     clr_cnt_reg;
    logic [CLR_W-1:0]     clr_cnt_next;

    // Entry table.
    logic                 ent_we;
    logic [EA_W-1:0]      ent_waddr;
    logic [ENT_W-1:0]     ent_wdata;
    logic [ENT_W-1:0]     ent_rdata;
    logic [START_W-1:0]   old_start;
    logic [COUNT_W-1:0]   old_len;

    // Free bitmap.
    logic                 map_we;
    logic [WA_W-1:0]      map_waddr;
    logic [WORD_W-1:0]    map_wdata;
    logic                 map_re;
    logic [WA_W-1:0]      map_raddr;
    logic [WORD_W-1:0]    map_rdata;
    logic [WORD_W-1:0]    init_word;

    // Marking engine.
    logic [WA_W-1:0]      mark_word_reg;
    logic [WA_W-1:0]      mark_first_reg;
    logic [WA_W-1:0]      mark_last_reg;
    logic [OFF_W-1:0]     mark_lo_reg;
    logic [OFF_W-1:0]     mark_hi_reg;
    logic                 mark_val_reg;
    logic [START_W-1:0]   src_first;
    logic [COUNT_W-1:0]   src_count;
    logic                 src_val;
    logic [CALC_W-1:0]    src_first_c;
    logic [CALC_W-1:0]    src_last_raw;
    logic [CALC_W-1:0]    src_last;
    logic [OFF_W-1:0]     mask_lo;
    logic [OFF_W-1:0]     mask_hi;
    logic [WORD_W-1:0]    mask;
    logic [WORD_W-1:0]    mark_new;

    // First-fit search.
    logic [WA_W-1:0]      scan_word_reg;
    logic [COUNT_W-1:0]   run_reg;
    logic [LZ_W-1:0]      lz [WORD_W];
    logic [RUN_W-1:0]     run_end [WORD_W];
    logic [WORD_W-1:0]    hit;
    logic [OFF_W-1:0]     hit_pos;
    logic [CALC_W-1:0]    found;
    logic [START_W-1:0]   found_start;

    // Pending result and output register.
    ffsa_pkg::status_t    res_status_reg;
    logic [START_W-1:0]   res_start_reg;
    logic [COUNT_W-1:0]   res_count_reg;
    ffsa_pkg::status_t    out_status_reg;
    logic [START_W-1:0]   out_start_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    function automatic logic run_empty(input logic [START_W-1:0] first,
                                       input logic [COUNT_W-1:0] count);
        return (count == '0) || (CALC_W'(first) >= CALC_W'(SECTORS));
    endfunction

    assign shifted = needed_bytes >> SECTOR_SHIFT;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg        <= operation;
            idx_reg       <= entry_index;
            needed_reg    <= COUNT_W'(shifted) + COUNT_W'(1);
            too_large_reg <= (shifted >= 32'(ffsa_pkg::MAX_RUN));
            rstart_reg    <= restore_start;
            rcount_reg    <= restore_count;
        end
    end

    // ---------------------------------------------------------------- clear
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear_wr && !sts.clear_last)
        begin
            clr_cnt_next = clr_cnt_reg + CLR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb
    begin
        init_word = '1;
        if (32'(clr_cnt_reg) == 32'(NWORDS - 1))
        begin
            init_word = {WORD_W{1'b1}} >> TAIL_PAD;
        end
        if (clr_cnt_reg == '0)
        begin
            init_word[0] = 1'b0;
        end
    end

    // ---------------------------------------------------------- entry table
    assign old_start = ent_rdata[ENT_W-1 -: START_W];
    assign old_len   = ent_rdata[COUNT_W-1:0];

    always_comb
    begin
        ent_we    = cmd.ent_we;
        ent_waddr = EA_W'(idx_reg);
        case (cmd.ent_src)
            ffsa_pkg::EWR_REST:  ent_wdata = {rstart_reg, rcount_reg};
            ffsa_pkg::EWR_FOUND: ent_wdata = {found_start, needed_reg};
            default:             ent_wdata = '0;
        endcase
        if (cmd.clear_wr)
        begin
            ent_we    = (32'(clr_cnt_reg) < 32'(ENTRIES));
            ent_waddr = EA_W'(clr_cnt_reg);
            ent_wdata = '0;
        end
    end

    ffsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (cmd.take),
        .raddr (EA_W'(entry_index)),
        .rdata (ent_rdata)
    );

    // ----------------------------------------------------------- free bitmap
    always_comb
    begin
        map_we    = cmd.mark_wr;
        map_waddr = mark_word_reg;
        map_wdata = mark_new;
        if (cmd.clear_wr)
        begin
            map_we    = (32'(clr_cnt_reg) < 32'(NWORDS));
            map_waddr = WA_W'(clr_cnt_reg);
            map_wdata = init_word;
        end
    end

    assign map_re = cmd.mark_rd | cmd.scan_start | cmd.scan_step;

    always_comb
    begin
        if (cmd.mark_rd)
        begin
            map_raddr = mark_word_reg;
        end
        else if (cmd.scan_start)
        begin
            map_raddr = '0;
        end
        else
        begin
            map_raddr = scan_word_reg + WA_W'(1);
        end
    end

    ffsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // -------------------------------------------------------- marking engine
    always_comb
    begin
        case (cmd.mark_src)
            ffsa_pkg::MSRC_OLD:
            begin
                src_first = old_start;
                src_count = old_len;
                src_val   = 1'b1;
            end
            ffsa_pkg::MSRC_REST:
            begin
                src_first = rstart_reg;
                src_count = rcount_reg;
                src_val   = 1'b0;
            end
            ffsa_pkg::MSRC_FOUND:
            begin
                src_first = found_start;
                src_count = needed_reg;
                src_val   = 1'b0;
            end
            default:
            begin
                src_first = '0;
                src_count = '0;
                src_val   = 1'b0;
            end
        endcase
        src_first_c  = CALC_W'(src_first);
        src_last_raw = src_first_c + CALC_W'(src_count) - CALC_W'(1);
        // Sectors past the end of the bitmap are skipped.
        src_last = (src_last_raw > CALC_W'(SECTORS - 1)) ? CALC_W'(SECTORS - 1) : src_last_raw;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_load)
        begin
            mark_word_reg  <= src_first_c[OFF_W +: WA_W];
            mark_first_reg <= src_first_c[OFF_W +: WA_W];
            mark_lo_reg    <= src_first_c[OFF_W-1:0];
            mark_last_reg  <= src_last[OFF_W +: WA_W];
            mark_hi_reg    <= src_last[OFF_W-1:0];
            mark_val_reg   <= src_val;
        end
        else if (cmd.mark_wr)
        begin
            mark_word_reg <= mark_word_reg + WA_W'(1);
        end
    end

    always_comb
    begin
        mask_lo  = (mark_word_reg == mark_first_reg) ? mark_lo_reg : '0;
        mask_hi  = (mark_word_reg == mark_last_reg) ? mark_hi_reg : OFF_W'(WORD_W - 1);
        mask     = ({WORD_W{1'b1}} << mask_lo) &
                   ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - mask_hi));
        mark_new = mark_val_reg ? (map_rdata | mask) : (map_rdata & ~mask);
    end

    // ------------------------------------------------------- first-fit search
    // lz[b] holds one plus the position of the last used sector at or below
    // bit b of the word, or zero when every lower bit is free. It is built as
    // a log-depth prefix, so the run length at each bit follows directly.
    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            lz[b] = map_rdata[b] ? '0 : LZ_W'(b + 1);
        end
        for (int k = 1; k < WORD_W; k = k * 2)
        begin
            for (int b = WORD_W - 1; b >= k; b--)
            begin
                if (lz[b] == '0)
                begin
                    lz[b] = lz[b - k];
                end
            end
        end
        for (int b = 0; b < WORD_W; b++)
        begin
            if (lz[b] == '0)
            begin
                run_end[b] = RUN_W'(run_reg) + RUN_W'(b + 1);
            end
            else
            begin
                run_end[b] = RUN_W'(b + 1) - RUN_W'(lz[b]);
            end
            hit[b] = (run_end[b] >= RUN_W'(needed_reg));
        end
        hit_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (hit[b])
            begin
                hit_pos = OFF_W'(b);
            end
        end
        found       = CALC_W'({scan_word_reg, hit_pos}) + CALC_W'(1) - CALC_W'(needed_reg);
        found_start = found[START_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_word_reg <= '0;
            run_reg       <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_word_reg <= scan_word_reg + WA_W'(1);
            run_reg       <= COUNT_W'(run_end[WORD_W-1]);
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_status)
                ffsa_pkg::ST_REUSED:
                begin
                    res_start_reg <= old_start;
                    res_count_reg <= old_len;
                end
                ffsa_pkg::ST_PLACED:
                begin
                    res_start_reg <= found_start;
                    res_count_reg <= needed_reg;
                end
                ffsa_pkg::ST_RESTORED:
                begin
                    res_start_reg <= rstart_reg;
                    res_count_reg <= rcount_reg;
                end
                default:
                begin
                    res_start_reg <= '0;
                    res_count_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    assign status       = out_status_reg;
    assign start_sector = out_start_reg;
    assign sector_count = out_count_reg;

    // ---------------------------------------------------------------- status
    always_comb
    begin
        sts.idx_bad    = (32'(idx_reg) >= 32'(ENTRIES));
        sts.is_restore = op_reg;
        sts.too_large  = too_large_reg;
        sts.reuse      = (old_len >= needed_reg);
        sts.old_empty  = run_empty(old_start, old_len);
        sts.rest_empty = run_empty(rstart_reg, rcount_reg);
        sts.mark_last  = (mark_word_reg == mark_last_reg);
        sts.scan_hit   = |hit;
        sts.scan_fit   = (found < CALC_W'(ffsa_pkg::START_LIMIT));
        sts.scan_last  = (scan_word_reg == WA_W'(NWORDS - 1));
        sts.clear_last = (clr_cnt_reg == CLR_W'(CLEAR_LEN - 1));
    end

endmodule

`default_nettype wire

// ===== tb/first_fit_sector_allocator_tb.sv =====
`default_nettype none

module first_fit_sector_allocator_tb;

    localparam int INDEX_W = ffsa_pkg::INDEX_W;
    localparam int BYTES_W = ffsa_pkg::BYTES_W;
    localparam int START_W = ffsa_pkg::START_W;
    localparam int COUNT_W = ffsa_pkg::COUNT_W;

    // Operation codes of the request beat.
    typedef enum bit {
        OP_ALLOCATE = 1'b0,
        OP_RESTORE  = 1'b1
    } op_e;

    // One request beat as the sender drives it.
    typedef struct packed {
        op_e                operation;
        logic [INDEX_W-1:0] entry_index;
        logic [BYTES_W-1:0] needed_bytes;
        logic [START_W-1:0] restore_start;
        logic [COUNT_W-1:0] restore_count;
    } request_t;

    // One response beat: the outcome of a request and the run the entry now owns.
    typedef struct packed {
        ffsa_pkg::status_t  status;
        logic [START_W-1:0] start_sector;
        logic [COUNT_W-1:0] sector_count;
    } grant_t;

    // The ledger mirrors the entry table and the free bitmap. Every accepted request
    // is played against the mirror, and the grant it should produce is queued until
    // the block hands back its own grant for comparison.
    class sector_ledger;
        logic [START_W-1:0] run_first [ffsa_pkg::DEF_ENTRIES];
        logic [COUNT_W-1:0] run_len [ffsa_pkg::DEF_ENTRIES];
        bit                 sector_open [ffsa_pkg::DEF_SECTORS];
        grant_t             pending [$];
        int                 failures;

        function new();
            foreach (run_first[i])
            begin
                run_first[i] = '0;
                run_len[i]   = '0;
            end
            foreach (sector_open[s]) sector_open[s] = 1'b1;
            sector_open[0] = 1'b0;
            failures = 0;
        endfunction

        // Sets the free flag over a run; sectors past the end of the disk are skipped.
        function void mark(int unsigned first, int unsigned count, bit val);
            for (int unsigned s = first; s < first + count && s < ffsa_pkg::DEF_SECTORS; s++)
                sector_open[s] = val;
        endfunction

        function grant_t predict_grant(request_t r);
            grant_t      g;
            int unsigned idx;
            int unsigned need;
            int unsigned run;
            int unsigned spot;
            g.status       = ffsa_pkg::ST_NOSPACE;
            g.start_sector = '0;
            g.sector_count = '0;
            idx = 32'(r.entry_index);
            if (idx >= ffsa_pkg::DEF_ENTRIES)
                return g;
            if (r.operation == OP_RESTORE)
            begin
                // The saved run is taken as given; the entry's old run stays marked.
                run_first[idx] = r.restore_start;
                run_len[idx]   = r.restore_count;
                mark(32'(r.restore_start), 32'(r.restore_count), 1'b0);
                g.status       = ffsa_pkg::ST_RESTORED;
                g.start_sector = r.restore_start;
                g.sector_count = r.restore_count;
                return g;
            end
            need = (r.needed_bytes >> ffsa_pkg::DEF_SECTOR_SHIFT) + 1;
            if (need > ffsa_pkg::MAX_RUN)
            begin
                g.status = ffsa_pkg::ST_TOOLARGE;
                return g;
            end
            if (32'(run_len[idx]) >= need)
            begin
                g.status       = ffsa_pkg::ST_REUSED;
                g.start_sector = run_first[idx];
                g.sector_count = run_len[idx];
                return g;
            end
            mark(32'(run_first[idx]), 32'(run_len[idx]), 1'b1);
            run_first[idx] = '0;
            run_len[idx]   = '0;
            spot = ffsa_pkg::START_LIMIT;
            run  = 0;
            for (int unsigned s = 0; s < ffsa_pkg::DEF_SECTORS; s++)
            begin
                if (sector_open[s])
                begin
                    run++;
                    if (run == need)
                    begin
                        spot = s + 1 - need;
                        break;
                    end
                end
                else
                begin
                    run = 0;
                end
            end
            if (spot >= ffsa_pkg::START_LIMIT)
                return g;
            run_first[idx] = spot[START_W-1:0];
            run_len[idx]   = need[COUNT_W-1:0];
            mark(spot, need, 1'b0);
            g.status       = ffsa_pkg::ST_PLACED;
            g.start_sector = spot[START_W-1:0];
            g.sector_count = need[COUNT_W-1:0];
            return g;
        endfunction

        function void take_request(request_t r);
            pending.push_back(predict_grant(r));
        endfunction

        function void check_grant(grant_t got);
            grant_t want;
            if (pending.size() == 0)
            begin
                $error("grant with no request outstanding: status %0d start %0d count %0d",
                       got.status, got.start_sector, got.sector_count);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.start_sector !== want.start_sector)
            begin
                $error("start_sector: expected %0d, got %0d",
                       want.start_sector, got.start_sector);
                failures++;
            end
            if (got.sector_count !== want.sector_count)
            begin
                $error("sector_count: expected %0d, got %0d",
                       want.sector_count, got.sector_count);
                failures++;
            end
        endfunction
    endclass

    // The clock runs with a period of two time units.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ffsa_req_if req_if ();
    ffsa_rsp_if rsp_if ();

    first_fit_sector_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    sector_ledger ledger = new();

    // The sender runs without gaps through some stretches of items.
    bit steady = 1'b0;

    // Most gaps are short or absent, with an occasional long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drives one request beat and waits until the block takes it. Inputs change only at
    // the falling edge; ready is looked at on the rising edge, where the beat moves.
    // The fields that the operation does not use carry random values, so the block is
    // seen to ignore them.
    task automatic issue(op_e op, int unsigned idx, logic [BYTES_W-1:0] bytes,
                         int unsigned rstart, int unsigned rcount);
        request_t    r;
        int unsigned gap;
        r.operation     = op;
        r.entry_index   = idx[INDEX_W-1:0];
        r.needed_bytes  = (op == OP_ALLOCATE) ? bytes : $urandom;
        r.restore_start = (op == OP_RESTORE) ? rstart[START_W-1:0]
                                             : START_W'($urandom_range(0, 4095));
        r.restore_count = (op == OP_RESTORE) ? rcount[COUNT_W-1:0]
                                             : COUNT_W'($urandom_range(0, 255));
        gap = steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid         = 1'b1;
        req_if.operation     = r.operation;
        req_if.entry_index   = r.entry_index;
        req_if.needed_bytes  = r.needed_bytes;
        req_if.restore_start = r.restore_start;
        req_if.restore_count = r.restore_count;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        ledger.take_request(r);
    endtask

    // Random traffic works mostly on a small set of entries, so that runs are reused,
    // outgrown, freed and placed again, and the bitmap fragments. Sizes are mostly a
    // few sectors; some come close to the largest run and a few are full 32-bit values,
    // which are nearly always too large. Restores drop runs anywhere on the disk.
    task automatic issue_random();
        int unsigned idx;
        int unsigned pick;
        logic [BYTES_W-1:0] bytes;
        idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            issue(OP_RESTORE, idx, '0, $urandom_range(0, 4095),
                  ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 255));
        end
        else
        begin
            if (pick < 16)
                bytes = $urandom;
            else if (pick < 19)
                bytes = $urandom_range(1044470, 1044490);
            else if (pick < 26)
                bytes = $urandom_range(0, 1044479);
            else if (pick < 46)
                bytes = $urandom_range(0, 64 * 4096 - 1);
            else
                bytes = $urandom_range(0, 16 * 4096 - 1);
            issue(OP_ALLOCATE, idx, bytes, 0, 0);
        end
    endtask

    // The receiver stalls at random, except through one window in four, where it takes
    // every beat at once.
    initial
    begin
        int unsigned stall;
        int unsigned cyc;
        rsp_if.ready = 1'b0;
        stall = 0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (((cyc / 400) % 4) == 3)
            begin
                rsp_if.ready = 1'b1;
            end
            else if (stall > 0)
            begin
                rsp_if.ready = 1'b0;
                stall--;
            end
            else
            begin
                rsp_if.ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Response beats are checked on the edge where they move.
    always @(posedge clk)
    begin
        grant_t got;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got.status       = ffsa_pkg::status_t'(rsp_if.status);
            got.start_sector = rsp_if.start_sector;
            got.sector_count = rsp_if.sector_count;
            ledger.check_grant(got);
        end
    end

    initial
    begin
        req_if.valid         = 1'b0;
        req_if.operation     = 1'b0;
        req_if.entry_index   = '0;
        req_if.needed_bytes  = '0;
        req_if.restore_start = '0;
        req_if.restore_count = '0;

        // Reset is held and then dropped on a falling edge. The block then
        // clears its tables before it raises ready; the first handshake waits for that.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The first allocate lands right after the header sector, then
        // the same entry is reused and outgrown.
        issue(OP_ALLOCATE, 0, 32'd0, 0, 0);
        issue(OP_ALLOCATE, 0, 32'd4095, 0, 0);
        issue(OP_ALLOCATE, 0, 32'd4096, 0, 0);
        // The largest run that fits, on the highest entry, and the sizes just past it.
        issue(OP_ALLOCATE, 1023, 32'd1044479, 0, 0);
        issue(OP_ALLOCATE, 2, 32'd1044480, 0, 0);
        issue(OP_ALLOCATE, 2, 32'hFFFF_FFFF, 0, 0);
        // A restore that runs off the end of the disk, and one with an absent run.
        issue(OP_RESTORE, 3, '0, 4095, 255);
        issue(OP_RESTORE, 4, '0, 0, 0);
        // The long restored run is big enough for a one-sector request.
        issue(OP_ALLOCATE, 3, 32'd0, 0, 0);
        issue(OP_ALLOCATE, 4, 32'd8191, 0, 0);
        // Restored runs of 255 sectors with 200-sector holes between them leave no hole
        // large enough for a full run, so the next largest request finds no space.
        for (int k = 0; k < 9; k++)
            issue(OP_RESTORE, 10 + k, '0, k * 455, 255);
        issue(OP_ALLOCATE, 5, 32'd1044479, 0, 0);
        // Growing an entry frees its run before the search, which may reuse that space.
        issue(OP_ALLOCATE, 0, 32'd8192, 0, 0);

        // Hold the sender until the block has answered everything.
        @(negedge clk);
        req_if.valid = 1'b0;
        while (ledger.pending.size() != 0)
            @(posedge clk);

        for (int n = 0; n < 1400; n++)
        begin
            steady = ((n / 100) % 3) == 2;
            if (n == 700)
            begin
                // A second drain in the middle of the random traffic.
                @(negedge clk);
                req_if.valid = 1'b0;
                while (ledger.pending.size() != 0)
                    @(posedge clk);
            end
            issue_random();
        end
        @(negedge clk);
        req_if.valid = 1'b0;

        // Wait for the last grants, then leave room for any stray beat.
        while (ledger.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        if (ledger.pending.size() != 0)
        begin
            $error("%0d grants never arrived", ledger.pending.size());
            ledger.failures++;
        end
        if (ledger.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // This timeout lies far past the end of the slowest correct run.
    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
